### rtl/core/char_lcd_4bit_writer_assert.svh
// Assertion macros used by the character LCD writer checker.
`ifndef CHAR_LCD_4BIT_WRITER_ASSERT_SVH
`define CHAR_LCD_4BIT_WRITER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CLCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/clcd_pkg.sv
// Types, constants and microprogram ROM of the character LCD writer.
package clcd_pkg;

  localparam logic [2:0] REQ_INIT       = 3'd0;
  localparam logic [2:0] REQ_CMD        = 3'd1;
  localparam logic [2:0] REQ_DATA       = 3'd2;
  localparam logic [2:0] REQ_LINE_START = 3'd3;
  localparam logic [2:0] REQ_LINE_END   = 3'd4;

  localparam int unsigned WAIT_W = 14;
  localparam logic [WAIT_W-1:0] WAIT_ZERO  = 14'd0;
  localparam logic [WAIT_W-1:0] WAIT_NIB   = 14'd5;
  localparam logic [WAIT_W-1:0] WAIT_BYTE  = 14'd37;
  localparam logic [WAIT_W-1:0] WAIT_LINE  = 14'd74;
  localparam logic [WAIT_W-1:0] WAIT_POWER = 14'd15000;
  localparam logic [WAIT_W-1:0] WAIT_FINAL = 14'd15037;

  localparam logic [7:0] CMD_LINE0  = 8'h80;
  localparam logic [7:0] CMD_LINE1  = 8'hc0;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [5:0] COL_MAX   = 6'd63;
  localparam logic [5:0] MAX_COLS  = 6'd32;
  localparam logic [5:0] CPL_RESET = 6'd16;

  localparam int unsigned UA_W = 5;
  typedef logic [UA_W-1:0] uaddr_t;

  localparam uaddr_t UA_INIT      = 5'd0;
  localparam uaddr_t UA_INIT_LAST = 5'd11;
  localparam uaddr_t UA_CMD_HI    = 5'd12;
  localparam uaddr_t UA_CMD_LO    = 5'd13;
  localparam uaddr_t UA_DATA_HI   = 5'd14;
  localparam uaddr_t UA_DATA_LO   = 5'd15;
  localparam uaddr_t UA_LINE_HI   = 5'd16;
  localparam uaddr_t UA_LINE_LO   = 5'd17;
  localparam uaddr_t UA_PAD       = 5'd18;
  localparam uaddr_t UA_PAD_HI    = 5'd19;
  localparam uaddr_t UA_PAD_LO    = 5'd20;

  typedef enum logic [1:0] {BS_INIT, BS_VALUE, BS_LINE, BS_SPACE} byte_sel_e;
  typedef enum logic [1:0] {WA_NIB, WA_BYTE, WA_LINE, WA_POWER} wait_sel_e;
  typedef enum logic [1:0] {COL_HOLD, COL_INC, COL_CLR} col_op_e;
  typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_PAD} last_mode_e;
  typedef enum logic [1:0] {NX_SEQ, NX_END, NX_JUMP, NX_BRANCH} next_e;

  typedef struct packed {
    logic       emit;
    logic       rs;
    byte_sel_e  bsel;
    logic [2:0] idx;
    logic       lo;
    logic       wb_power;
    wait_sel_e  wa;
    col_op_e    col;
    last_mode_e last;
    next_e      nxt;
    uaddr_t     target;
  } uword_t;

  typedef struct packed {
    uword_t word;
    logic   fire;
  } seq_ctrl_t;

  typedef struct packed {
    logic pad_ok;
    logic slot_free;
  } dp_stat_t;

  function automatic logic [7:0] init_byte(logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h33;
      3'd2:    b = 8'h32;
      3'd3:    b = 8'h28;
      3'd4:    b = 8'h0c;
      3'd5:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic uword_t uw(logic emit, logic rs, byte_sel_e bsel, logic [2:0] idx,
                                logic lo, logic wb, wait_sel_e wa, col_op_e col,
                                last_mode_e last, next_e nxt, uaddr_t target);
    uword_t w;
    w.emit     = emit;
    w.rs       = rs;
    w.bsel     = bsel;
    w.idx      = idx;
    w.lo       = lo;
    w.wb_power = wb;
    w.wa       = wa;
    w.col      = col;
    w.last     = last;
    w.nxt      = nxt;
    w.target   = target;
    return w;
  endfunction

  function automatic uword_t ucode(uaddr_t a);
    uword_t     w;
    logic       fin;
    wait_sel_e  wa;
    last_mode_e lm;
    next_e      nx;
    fin = (a == UA_INIT_LAST);
    wa  = !a[0] ? WA_NIB : (fin ? WA_POWER : WA_BYTE);
    lm  = fin ? LAST_YES : LAST_NO;
    nx  = fin ? NX_END : NX_SEQ;
    if (a <= UA_INIT_LAST) begin
      w = uw(1'b1, 1'b0, BS_INIT, a[3:1], a[0], (a == UA_INIT), wa, COL_HOLD, lm, nx,
             UA_INIT);
    end else begin
      case (a)
        UA_CMD_HI:  w = uw(1'b1, 1'b0, BS_VALUE, 3'd0, 1'b0, 1'b0, WA_NIB, COL_HOLD,
                           LAST_NO, NX_SEQ, UA_INIT);
        UA_CMD_LO:  w = uw(1'b1, 1'b0, BS_VALUE, 3'd0, 1'b1, 1'b0, WA_BYTE, COL_HOLD,
                           LAST_YES, NX_END, UA_INIT);
        UA_DATA_HI: w = uw(1'b1, 1'b1, BS_VALUE, 3'd0, 1'b0, 1'b0, WA_NIB, COL_HOLD,
                           LAST_NO, NX_SEQ, UA_INIT);
        UA_DATA_LO: w = uw(1'b1, 1'b1, BS_VALUE, 3'd0, 1'b1, 1'b0, WA_BYTE, COL_INC,
                           LAST_YES, NX_END, UA_INIT);
        UA_LINE_HI: w = uw(1'b1, 1'b0, BS_LINE, 3'd0, 1'b0, 1'b0, WA_NIB, COL_HOLD,
                           LAST_NO, NX_SEQ, UA_INIT);
        UA_LINE_LO: w = uw(1'b1, 1'b0, BS_LINE, 3'd0, 1'b1, 1'b0, WA_LINE, COL_CLR,
                           LAST_YES, NX_END, UA_INIT);
        UA_PAD:     w = uw(1'b0, 1'b1, BS_SPACE, 3'd0, 1'b0, 1'b0, WA_NIB, COL_HOLD,
                           LAST_NO, NX_BRANCH, UA_INIT);
        UA_PAD_HI:  w = uw(1'b1, 1'b1, BS_SPACE, 3'd0, 1'b0, 1'b0, WA_NIB, COL_HOLD,
                           LAST_NO, NX_SEQ, UA_INIT);
        UA_PAD_LO:  w = uw(1'b1, 1'b1, BS_SPACE, 3'd0, 1'b1, 1'b0, WA_BYTE, COL_INC,
                           LAST_PAD, NX_JUMP, UA_PAD);
        default:    w = uw(1'b0, 1'b0, BS_INIT, 3'd0, 1'b0, 1'b0, WA_NIB, COL_HOLD,
                           LAST_NO, NX_END, UA_INIT);
      endcase
    end
    return w;
  endfunction

endpackage

### rtl/core/clcd_req_if.sv
// Request channel: valid/ready handshake with the request payload.
interface clcd_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] value;
  logic       line_select;
  logic       clear_rest;

  modport source (output valid, req_type, value, line_select, clear_rest, input ready);
  modport sink   (input valid, req_type, value, line_select, clear_rest, output ready);
endinterface

### rtl/core/clcd_nib_if.sv
// Nibble channel: valid/ready handshake with one LCD nibble transfer.
interface clcd_nib_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [13:0] wait_before_us;
  logic [13:0] wait_after_us;
  logic        last;

  modport source (output valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                  input ready);
  modport sink   (input valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                  output ready);
endinterface

### rtl/core/clcd_seq.sv
// Microcode sequencer: step counter, control ROM and jump logic.
module clcd_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2:0]            req_type_i,
  input  clcd_pkg::dp_stat_t    stat_i,
  output clcd_pkg::seq_ctrl_t   ctrl_o,
  output logic                  busy_o
);

  logic             busy_q, busy_d;
  clcd_pkg::uaddr_t pc_q, pc_d;
  clcd_pkg::uaddr_t entry;
  logic             entry_ok;
  clcd_pkg::uword_t word;
  logic             fire;

  always_comb begin
    entry_ok = 1'b1;
    case (req_type_i)
      clcd_pkg::REQ_INIT:       entry = clcd_pkg::UA_INIT;
      clcd_pkg::REQ_CMD:        entry = clcd_pkg::UA_CMD_HI;
      clcd_pkg::REQ_DATA:       entry = clcd_pkg::UA_DATA_HI;
      clcd_pkg::REQ_LINE_START: entry = clcd_pkg::UA_LINE_HI;
      clcd_pkg::REQ_LINE_END:   entry = clcd_pkg::UA_PAD;
      default: begin
        entry    = clcd_pkg::UA_INIT;
        entry_ok = 1'b0;
      end
    endcase
  end

  assign word = clcd_pkg::ucode(pc_q);
  assign fire = busy_q && (!word.emit || stat_i.slot_free);

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (start_i) begin
      busy_d = entry_ok;
      pc_d   = entry;
    end else if (fire) begin
      case (word.nxt)
        clcd_pkg::NX_SEQ:  pc_d = pc_q + 1'b1;
        clcd_pkg::NX_END:  busy_d = 1'b0;
        clcd_pkg::NX_JUMP: pc_d = word.target;
        clcd_pkg::NX_BRANCH: begin
          if (stat_i.pad_ok) begin
            pc_d = pc_q + 1'b1;
          end else begin
            busy_d = 1'b0;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= clcd_pkg::UA_INIT;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign ctrl_o.word = word;
  assign ctrl_o.fire = fire;
  assign busy_o      = busy_q;

endmodule

### rtl/core/clcd_dp.sv
// Datapath: request latch, column counter, byte and wait select, output register.
module clcd_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [7:0]          value_i,
  input  logic                line_select_i,
  input  logic                clear_rest_i,
  input  logic                cfg_we_i,
  input  logic [5:0]          cfg_wdata_i,
  input  clcd_pkg::seq_ctrl_t ctrl_i,
  output clcd_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                reg_select_o,
  output logic [3:0]          nibble_o,
  output logic [13:0]         wait_before_us_o,
  output logic [13:0]         wait_after_us_o,
  output logic                last_o
);

  logic [7:0]  value_q;
  logic        line_select_q;
  logic        clear_rest_q;
  logic [5:0]  cpl_q;
  logic [5:0]  col_q, col_d;
  logic        out_valid_q, out_valid_d;
  logic        rs_q;
  logic [3:0]  nib_q;
  logic [13:0] wb_q;
  logic [13:0] wa_q;
  logic        last_q;

  logic [5:0]  target;
  logic [6:0]  col_inc;
  logic [7:0]  byte_sel;
  logic [3:0]  nib_d;
  logic [13:0] wb_d, wa_d;
  logic        last_d;
  logic        emit;

  clcd_pkg::uword_t w;

  assign w       = ctrl_i.word;
  assign emit    = ctrl_i.fire && w.emit;
  assign target  = (cpl_q > clcd_pkg::MAX_COLS) ? clcd_pkg::MAX_COLS : cpl_q;
  assign col_inc = {1'b0, col_q} + 7'd1;

  always_comb begin
    case (w.bsel)
      clcd_pkg::BS_INIT:  byte_sel = clcd_pkg::init_byte(w.idx);
      clcd_pkg::BS_VALUE: byte_sel = value_q;
      clcd_pkg::BS_LINE:  byte_sel = line_select_q ? clcd_pkg::CMD_LINE1 : clcd_pkg::CMD_LINE0;
      clcd_pkg::BS_SPACE: byte_sel = clcd_pkg::CHAR_SPACE;
      default:            byte_sel = clcd_pkg::CHAR_SPACE;
    endcase
    nib_d = w.lo ? byte_sel[3:0] : byte_sel[7:4];
    wb_d  = w.wb_power ? clcd_pkg::WAIT_POWER : clcd_pkg::WAIT_ZERO;
    case (w.wa)
      clcd_pkg::WA_NIB:   wa_d = clcd_pkg::WAIT_NIB;
      clcd_pkg::WA_BYTE:  wa_d = clcd_pkg::WAIT_BYTE;
      clcd_pkg::WA_LINE:  wa_d = clcd_pkg::WAIT_LINE;
      clcd_pkg::WA_POWER: wa_d = clcd_pkg::WAIT_FINAL;
      default:            wa_d = clcd_pkg::WAIT_BYTE;
    endcase
    case (w.last)
      clcd_pkg::LAST_NO:  last_d = 1'b0;
      clcd_pkg::LAST_YES: last_d = 1'b1;
      clcd_pkg::LAST_PAD: last_d = (col_inc >= {1'b0, target});
      default:            last_d = 1'b0;
    endcase
  end

  always_comb begin
    col_d = col_q;
    if (ctrl_i.fire) begin
      case (w.col)
        clcd_pkg::COL_INC: col_d = (col_q < clcd_pkg::COL_MAX) ? col_inc[5:0] : col_q;
        clcd_pkg::COL_CLR: col_d = 6'd0;
        default:           col_d = col_q;
      endcase
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpl_q       <= clcd_pkg::CPL_RESET;
      col_q       <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cpl_q <= cfg_wdata_i;
      end
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q       <= value_i;
      line_select_q <= line_select_i;
      clear_rest_q  <= clear_rest_i;
    end
    if (emit) begin
      rs_q   <= w.rs;
      nib_q  <= nib_d;
      wb_q   <= wb_d;
      wa_q   <= wa_d;
      last_q <= last_d;
    end
  end

  assign stat_o.pad_ok    = clear_rest_q && (col_q < target);
  assign stat_o.slot_free = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign reg_select_o     = rs_q;
  assign nibble_o         = nib_q;
  assign wait_before_us_o = wb_q;
  assign wait_after_us_o  = wa_q;
  assign last_o           = last_q;

endmodule

### rtl/core/char_lcd_4bit_writer.sv
// Character LCD 4-bit writer top level.
//
// Requests arrive on req_i (init, command byte, data byte, line start, line
// end); each turns into a run of nibble transfers on nib_o (none for a line
// end with nothing to pad), high nibble first, each carrying RS, D7..D4 and
// the waits around its enable pulse. last marks the final transfer of a
// request. The line width, capped at 32 as the padding target, is written
// through cfg_we_i/cfg_wdata_i; the user must write it only while idle, the
// block itself does not enforce this. A microcode step counter walks a ROM
// program, one step per cycle unless nib_o stalls: init 12 steps, a command,
// data or line start byte 2 steps, line end 1 step plus 3 per padding space
// (at most 32). A request occupies the block for its steps. Unknown request
// codes produce nothing. The first nibble goes out through the step counter
// and the output register, for line end after its branch step. req_i.ready
// is high only while no request is being worked. A stalled nib_o holds its
// transfer and freezes the step counter; the output register lets the final
// nibble wait while the next request is taken. Reset clears the column
// count, empties the output and sets the line width to 16.
module char_lcd_4bit_writer (
  input  logic          clk_i,
  input  logic          rst_ni,
  clcd_req_if.sink      req_i,
  clcd_nib_if.source    nib_o,
  input  logic          cfg_we_i,
  input  logic [5:0]    cfg_wdata_i
);

  clcd_pkg::seq_ctrl_t ctrl;
  clcd_pkg::dp_stat_t  stat;
  logic                busy;
  logic                req_xfer;

  assign req_i.ready = !busy;
  assign req_xfer    = req_i.valid && !busy;

  clcd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (req_xfer),
    .req_type_i (req_i.req_type),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  clcd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (req_xfer),
    .value_i          (req_i.value),
    .line_select_i    (req_i.line_select),
    .clear_rest_i     (req_i.clear_rest),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .out_valid_o      (nib_o.valid),
    .out_ready_i      (nib_o.ready),
    .reg_select_o     (nib_o.reg_select),
    .nibble_o         (nib_o.nibble),
    .wait_before_us_o (nib_o.wait_before_us),
    .wait_after_us_o  (nib_o.wait_after_us),
    .last_o           (nib_o.last)
  );

endmodule

### rtl/core/clcd_checker.sv
// Port-level checker for the character LCD writer, bound to the top level.
`include "char_lcd_4bit_writer_assert.svh"

module clcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_ready_i,
  input logic        nib_valid_i,
  input logic        nib_ready_i,
  input logic        nib_last_i,
  input logic [3:0]  nib_nibble_i,
  input logic [13:0] nib_wait_before_i,
  input logic [13:0] nib_wait_after_i
);

  `CLCD_ASSERT_NEXT(a_nib_hold, nib_valid_i && !nib_ready_i,
                    nib_valid_i && $stable(nib_nibble_i) && $stable(nib_last_i),
                    "stalled nibble changed")
  `CLCD_ASSERT_NOW(a_busy_mid, nib_valid_i && !nib_last_i, !req_ready_i,
                   "request taken mid sequence")
  `CLCD_ASSERT_NOW(a_wait_before, nib_valid_i,
                   nib_wait_before_i == clcd_pkg::WAIT_ZERO ||
                   nib_wait_before_i == clcd_pkg::WAIT_POWER,
                   "bad wait before")
  `CLCD_ASSERT_NOW(a_wait_after, nib_valid_i,
                   nib_wait_after_i == clcd_pkg::WAIT_NIB ||
                   nib_wait_after_i == clcd_pkg::WAIT_BYTE ||
                   nib_wait_after_i == clcd_pkg::WAIT_LINE ||
                   nib_wait_after_i == clcd_pkg::WAIT_FINAL,
                   "bad wait after")

endmodule

bind char_lcd_4bit_writer clcd_checker u_clcd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_ready_i       (req_i.ready),
  .nib_valid_i       (nib_o.valid),
  .nib_ready_i       (nib_o.ready),
  .nib_last_i        (nib_o.last),
  .nib_nibble_i      (nib_o.nibble),
  .nib_wait_before_i (nib_o.wait_before_us),
  .nib_wait_after_i  (nib_o.wait_after_us)
);

### verif/char_lcd_4bit_writer_tb.sv
// Self-checking testbench: LCD requests in, nibble transfers checked against a predictor.
module char_lcd_4bit_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REQ_RSVD5 = 3'd5;
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int SEG_ITEMS     = 6;
  localparam int LONG_LINE     = 66;

  localparam logic [47:0] POWER_ON_SEQ = 48'h33_33_32_28_0c_01;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nib;
    logic [13:0] wb;
    logic [13:0] wa;
    logic        last;
  } lcd_xfer_t;

  typedef struct packed {
    logic [2:0] rt;
    logic [7:0] val;
    logic       sel;
    logic       clr;
    logic       chk;
    logic [6:0] n_xfers;
  } lcd_row_t;

  localparam lcd_row_t DIRECTED_ROWS [0:19] = '{
    '{clcd_pkg::REQ_INIT,       8'h00, 1'b0, 1'b0, 1'b1, 7'd12},
    '{clcd_pkg::REQ_CMD,        8'h00, 1'b0, 1'b0, 1'b1, 7'd2},
    '{clcd_pkg::REQ_CMD,        8'hff, 1'b1, 1'b1, 1'b1, 7'd2},
    '{clcd_pkg::REQ_DATA,       8'h00, 1'b0, 1'b0, 1'b1, 7'd2},
    '{clcd_pkg::REQ_DATA,       8'hff, 1'b0, 1'b0, 1'b1, 7'd2},
    '{clcd_pkg::REQ_DATA,       8'ha5, 1'b1, 1'b1, 1'b1, 7'd2},
    '{clcd_pkg::REQ_LINE_END,   8'h00, 1'b1, 1'b0, 1'b1, 7'd0},
    '{clcd_pkg::REQ_LINE_END,   8'h00, 1'b0, 1'b1, 1'b0, 7'd0},
    '{clcd_pkg::REQ_LINE_END,   8'hff, 1'b0, 1'b1, 1'b0, 7'd0},
    '{clcd_pkg::REQ_LINE_START, 8'h00, 1'b0, 1'b0, 1'b1, 7'd2},
    '{clcd_pkg::REQ_LINE_START, 8'hff, 1'b1, 1'b1, 1'b1, 7'd2},
    '{clcd_pkg::REQ_LINE_END,   8'h00, 1'b0, 1'b1, 1'b1, 7'd32},
    '{REQ_RSVD5,                8'hff, 1'b1, 1'b1, 1'b1, 7'd0},
    '{REQ_RSVD6,                8'h00, 1'b0, 1'b1, 1'b1, 7'd0},
    '{REQ_RSVD7,                8'h5a, 1'b1, 1'b0, 1'b1, 7'd0},
    '{clcd_pkg::REQ_LINE_START, 8'h00, 1'b0, 1'b0, 1'b1, 7'd2},
    '{clcd_pkg::REQ_DATA,       8'h5a, 1'b0, 1'b0, 1'b1, 7'd2},
    '{clcd_pkg::REQ_LINE_END,   8'h00, 1'b0, 1'b0, 1'b1, 7'd0},
    '{clcd_pkg::REQ_INIT,       8'hff, 1'b1, 1'b1, 1'b1, 7'd12},
    '{clcd_pkg::REQ_LINE_END,   8'h00, 1'b0, 1'b1, 1'b0, 7'd0}
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [5:0] cfg_wdata_i = 6'd0;
  logic       req_taken   = 1'b0;

  logic [5:0] line_width = clcd_pkg::CPL_RESET;
  logic [5:0] col_count  = 6'd0;
  lcd_xfer_t  expected_xfers[$];

  int burst_len    = 0;
  int n_errors     = 0;
  int n_sent       = 0;
  int stall_cycles = 0;
  int tx_idle_pct  = 22;
  int rx_idle_pct  = 59;

  clcd_req_if req_if();
  clcd_nib_if nib_if();

  char_lcd_4bit_writer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .nib_o       (nib_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  task automatic push_byte(input logic rs, input logic [7:0] b, input logic [13:0] wb,
                           input logic [13:0] wa, input logic fin);
    expected_xfers.push_back(lcd_xfer_t'{rs, b[7:4], wb, clcd_pkg::WAIT_NIB, 1'b0});
    expected_xfers.push_back(lcd_xfer_t'{rs, b[3:0], clcd_pkg::WAIT_ZERO, wa, fin});
    burst_len += 2;
  endtask

  task automatic predict_request(input logic [2:0] rt, input logic [7:0] val,
                                 input logic sel, input logic clr);
    logic [5:0] target;
    burst_len = 0;
    target = (line_width > clcd_pkg::MAX_COLS) ? clcd_pkg::MAX_COLS : line_width;
    case (rt)
      clcd_pkg::REQ_INIT: begin
        for (int i = 0; i < 6; i++)
          push_byte(1'b0, POWER_ON_SEQ[47-8*i -: 8],
                    (i == 0) ? clcd_pkg::WAIT_POWER : clcd_pkg::WAIT_ZERO,
                    (i == 5) ? clcd_pkg::WAIT_FINAL : clcd_pkg::WAIT_BYTE, i == 5);
      end
      clcd_pkg::REQ_CMD: push_byte(1'b0, val, clcd_pkg::WAIT_ZERO, clcd_pkg::WAIT_BYTE, 1'b1);
      clcd_pkg::REQ_DATA: begin
        push_byte(1'b1, val, clcd_pkg::WAIT_ZERO, clcd_pkg::WAIT_BYTE, 1'b1);
        if (col_count < clcd_pkg::COL_MAX) col_count = col_count + 6'd1;
      end
      clcd_pkg::REQ_LINE_START: begin
        push_byte(1'b0, sel ? clcd_pkg::CMD_LINE1 : clcd_pkg::CMD_LINE0,
                  clcd_pkg::WAIT_ZERO, clcd_pkg::WAIT_LINE, 1'b1);
        col_count = 6'd0;
      end
      clcd_pkg::REQ_LINE_END: begin
        if (clr) begin
          while (col_count < target) begin
            col_count = col_count + 6'd1;
            push_byte(1'b1, clcd_pkg::CHAR_SPACE, clcd_pkg::WAIT_ZERO, clcd_pkg::WAIT_BYTE,
                      col_count == target);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_xfer();
    lcd_xfer_t want;
    if (expected_xfers.size() == 0) begin
      report_mismatch($sformatf("transfer with nothing expected: rs=%0b nibble=%h",
                                nib_if.reg_select, nib_if.nibble));
      return;
    end
    want = expected_xfers.pop_front();
    if (nib_if.reg_select !== want.rs)
      report_mismatch($sformatf("reg_select %b, want %b", nib_if.reg_select, want.rs));
    if (nib_if.nibble !== want.nib)
      report_mismatch($sformatf("nibble %h, want %h", nib_if.nibble, want.nib));
    if (nib_if.wait_before_us !== want.wb)
      report_mismatch($sformatf("wait_before_us %0d, want %0d", nib_if.wait_before_us, want.wb));
    if (nib_if.wait_after_us !== want.wa)
      report_mismatch($sformatf("wait_after_us %0d, want %0d", nib_if.wait_after_us, want.wa));
    if (nib_if.last !== want.last)
      report_mismatch($sformatf("last %b, want %b", nib_if.last, want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_taken <= req_if.valid && req_if.ready;
      if (cfg_we_i) line_width = cfg_wdata_i;
      if (req_if.valid && req_if.ready)
        predict_request(req_if.req_type, req_if.value, req_if.line_select,
                        req_if.clear_rest);
      if (nib_if.valid && nib_if.ready) check_xfer();
      if ((req_if.valid && req_if.ready) || (nib_if.valid && nib_if.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("** char_lcd_4bit_writer: FAILED **");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    nib_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_req(input logic [2:0] rt, input logic [7:0] val, input logic sel,
                          input logic clr);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= rt;
    req_if.value       <= val;
    req_if.line_select <= sel;
    req_if.clear_rest  <= clr;
    do @(negedge clk_i); while (!req_taken);
    n_sent++;
  endtask

  task automatic send_line(input int n_chars);
    send_req(clcd_pkg::REQ_LINE_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
             1'($urandom_range(1)));
    repeat (n_chars)
      send_req(clcd_pkg::REQ_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)),
               1'($urandom_range(1)));
    send_req(clcd_pkg::REQ_LINE_END, 8'($urandom_range(255)), 1'($urandom_range(1)),
             $urandom_range(9) != 0);
  endtask

  task automatic drain_outputs();
    req_if.valid <= 1'b0;
    while (expected_xfers.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_width(input logic [5:0] w);
    drain_outputs();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    lcd_row_t   row;
    logic [5:0] width;
    int         seg_end;
    req_if.valid       = 1'b0;
    req_if.req_type    = clcd_pkg::REQ_INIT;
    req_if.value       = 8'h00;
    req_if.line_select = 1'b0;
    req_if.clear_rest  = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < 20; i++) begin
      row = DIRECTED_ROWS[i];
      send_req(row.rt, row.val, row.sel, row.clr);
      if (row.chk && burst_len != row.n_xfers)
        report_mismatch($sformatf("row %0d: %0d transfers predicted, table has %0d",
                                  i, burst_len, row.n_xfers));
    end

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0:       width = 6'd1;
        1:       width = clcd_pkg::MAX_COLS;
        2:       width = clcd_pkg::COL_MAX;
        3:       width = 6'd0;
        default: width = 6'($urandom_range(63));
      endcase
      write_width(width);
      if (seg < 2) begin
        tx_idle_pct = 22;
        rx_idle_pct = 59;
      end else if (seg < 4) begin
        tx_idle_pct = 59;
        rx_idle_pct = 22;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // run the column count into saturation once
      if (seg == 2) send_line(LONG_LINE);
      seg_end = n_sent + SEG_ITEMS;
      while (n_sent < seg_end) begin
        if ($urandom_range(99) < 55) send_line(int'($urandom_range(34)));
        else send_req(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
      end
    end

    drain_outputs();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (n_errors == 0 && expected_xfers.size() == 0) begin
      $display("** char_lcd_4bit_writer: PASSED **");
    end else begin
      $display("** char_lcd_4bit_writer: FAILED **");
    end
    $finish;
  end

endmodule
